>>> src/assert_macros.svh
// Assertion macros shared by the gait generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gait generator assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gait generator assertion failed");

`endif

>>> src/wgsvg_pkg.sv
// Shared widths, types and codes of the gait swing velocity generator.
package wgsvg_pkg;

	// Leg count and timer width.
	localparam int NUM_LEGS   = 4;
	localparam int TIMER_BITS = 16;
	localparam int LEG_W      = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
	localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(NUM_LEGS - 1);

	// Field widths.
	localparam int IDX_W   = 2;
	localparam int STEP_W  = 18;
	localparam int DUR_W   = 16;
	localparam int INC_W   = 8;
	localparam int INV_W   = 23;
	localparam int SCALE_W = 33;
	localparam int VEL_W   = 24;

	// Internal arithmetic widths.
	localparam int GAIN_W = 35;
	localparam int H_W    = 37;
	localparam int P_W    = 29;
	localparam int V_W    = 25;
	localparam int MA_W   = 37;
	localparam int MB_W   = 29;
	localparam int PROD_W = MA_W + MB_W;
	localparam int R_W    = 42;
	localparam int CMP_W  = ((TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W) + 2;

	// Port widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int IN_W       = 8;
	localparam int OUT_W      = 104;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD_STEP   = 3'd0,
		REG_SIDE_STEP      = 3'd1,
		REG_STEP_HEIGHT    = 3'd2,
		REG_STEP_DURATION  = 3'd3,
		REG_TICK_INCREMENT = 3'd4,
		REG_INV_DURATION   = 3'd5
	} reg_idx_t;

	// Datapath operations, one product each.
	typedef enum logic [3:0] {
		OP_GX, OP_GY, OP_GZ, OP_PHASE,
		OP_X1, OP_X2, OP_X3,
		OP_Z1, OP_Z2, OP_Z3, OP_Z4,
		OP_VX, OP_VY, OP_VZ
	} op_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic signed [STEP_W-1:0] forward_step;
		logic signed [STEP_W-1:0] side_step;
		logic signed [STEP_W-1:0] step_height;
		logic [DUR_W-1:0]         step_duration;
		logic [INC_W-1:0]         tick_increment;
		logic [INV_W-1:0]         inv_duration;
		logic [SCALE_W-1:0]       scale;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		op_t              op;
		logic             capture;
		logic             mul;
		logic             wb;
		logic             leg_start;
		logic             load_out;
		logic [LEG_W-1:0] leg;
	} cmd_t;

endpackage

>>> src/wgsvg_regs.sv
// Configuration register file of the gait generator.
module wgsvg_regs import wgsvg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic signed [STEP_W-1:0] fwd_q;
	logic signed [STEP_W-1:0] side_q;
	logic signed [STEP_W-1:0] height_q;
	logic [DUR_W-1:0]         dur_q;
	logic [INC_W-1:0]         inc_q;
	logic [INV_W-1:0]         inv_q;
	logic [SCALE_W-1:0]       scale_q;
	reg_idx_t                 idx;

	assign idx = reg_idx_t'(wr_index);

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q    <= STEP_W'(19661);
			side_q   <= '0;
			height_q <= STEP_W'(6554);
			dur_q    <= DUR_W'(1000);
			inc_q    <= INC_W'(1);
			inv_q    <= INV_W'(16777);
		end else if (wr_en) begin
			unique case (idx)
				REG_FORWARD_STEP:   fwd_q    <= STEP_W'(wr_data);
				REG_SIDE_STEP:      side_q   <= STEP_W'(wr_data);
				REG_STEP_HEIGHT:    height_q <= STEP_W'(wr_data);
				REG_STEP_DURATION:  dur_q    <= DUR_W'(wr_data);
				REG_TICK_INCREMENT: inc_q    <= INC_W'(wr_data);
				REG_INV_DURATION:   inv_q    <= INV_W'(wr_data);
				default: ;
			endcase
		end
	end

	// Velocity scale inv_duration * 1000, updated in the cycle after its source.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(64'd16777000);
		end else begin
			scale_q <= {inv_q, 10'b0} - SCALE_W'({inv_q, 4'b0}) - SCALE_W'({inv_q, 3'b0});
		end
	end

	assign cfg.forward_step   = fwd_q;
	assign cfg.side_step      = side_q;
	assign cfg.step_height    = height_q;
	assign cfg.step_duration  = dur_q;
	assign cfg.tick_increment = inc_q;
	assign cfg.inv_duration   = inv_q;
	assign cfg.scale          = scale_q;

endmodule

>>> src/wgsvg_ctrl.sv
// Controller state machine: sequences the gains, the legs and the product chain.
`include "assert_macros.svh"
module wgsvg_ctrl import wgsvg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_run,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic swing,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_WB   = 5'b00100,
		ST_LEG  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [LEG_W-1:0] leg_q, leg_d;
	logic             out_valid_q;
	logic             in_acc;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		leg_d   = leg_q;
		cmd     = '0;
		cmd.op  = op_q;
		cmd.leg = leg_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_run) begin
					cmd.capture = 1'b1;
					op_d        = OP_GX;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_MUL;
				case (op_q)
					OP_GX:    op_d = OP_GY;
					OP_GY:    op_d = OP_GZ;
					OP_GZ: begin
						leg_d   = '0;
						state_d = ST_LEG;
					end
					OP_PHASE: op_d = OP_X1;
					OP_X1:    op_d = OP_X2;
					OP_X2:    op_d = OP_X3;
					OP_X3:    op_d = OP_Z1;
					OP_Z1:    op_d = OP_Z2;
					OP_Z2:    op_d = OP_Z3;
					OP_Z3:    op_d = OP_Z4;
					OP_Z4:    op_d = OP_VX;
					OP_VX:    op_d = OP_VY;
					OP_VY:    op_d = OP_VZ;
					OP_VZ:    state_d = ST_EMIT;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_LEG: begin
				cmd.leg_start = 1'b1;
				if (swing) begin
					op_d    = OP_PHASE;
					state_d = ST_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					if (leg_q == LAST_LEG) begin
						state_d = ST_IDLE;
					end else begin
						leg_d   = leg_q + 1'b1;
						state_d = ST_LEG;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers and the output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_GX;
			leg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			leg_q   <= leg_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_IMP(a_load_slot_free, cmd.load_out, !out_valid_q || out_ready)
	`ASSERT_NEXT(a_busy_after_start, in_acc && in_run, !in_ready)
	`ASSERT_NEXT(a_last_leg_idle, cmd.load_out && (leg_q == LAST_LEG), state_q == ST_IDLE)

endmodule

>>> src/wgsvg_dp.sv
// Datapath: leg timers, shared multiplier with rounding, velocity and output registers.
`include "assert_macros.svh"
module wgsvg_dp import wgsvg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_walk,
	input  cmd_t                    cmd,
	output logic                    swing,
	output logic [IDX_W-1:0]        out_leg,
	output logic signed [VEL_W-1:0] out_vx,
	output logic signed [VEL_W-1:0] out_vy,
	output logic signed [VEL_W-1:0] out_vz,
	output logic signed [VEL_W-1:0] out_body,
	output logic                    out_last
);

	localparam longint Q24 = 64'sd16777216;
	localparam logic signed [R_W-1:0] K_X1 = R_W'(150 * Q24);
	localparam logic signed [R_W-1:0] K_X3 = R_W'(-Q24);
	localparam logic signed [R_W-1:0] K_Z1 = R_W'(-3072 * Q24);
	localparam logic signed [R_W-1:0] K_Z2 = R_W'(768 * Q24);
	localparam logic signed [H_W-1:0] H_X0 = H_W'(-300 * Q24);
	localparam logic signed [H_W-1:0] H_Z0 = H_W'(3840 * Q24);
	localparam logic [V_W-1:0] V_ONE = V_W'(Q24);
	localparam logic [PROD_W-1:0] PHASE_LIM = PROD_W'(Q24 >>> 2);
	localparam logic signed [R_W-1:0] VMAX = R_W'(64'sd8388607);
	localparam logic signed [R_W-1:0] VMIN = R_W'(-64'sd8388608);

	// Reset pattern of the leg timers, repeating every four legs.
	function automatic logic [TIMER_BITS-1:0] timer_reset(input int k);
		logic [TIMER_BITS-1:0] v;
		case (k[1:0])
			2'd0:    v = '0;
			2'd1:    v = TIMER_BITS'(750);
			2'd2:    v = TIMER_BITS'(250);
			default: v = TIMER_BITS'(500);
		endcase
		return v;
	endfunction

	// Clamp to the signed output range.
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [R_W-1:0] x);
		logic signed [VEL_W-1:0] y;
		if (x > VMAX) begin
			y = VEL_W'(VMAX);
		end else if (x < VMIN) begin
			y = VEL_W'(VMIN);
		end else begin
			y = VEL_W'(x);
		end
		return y;
	endfunction

	logic [TIMER_BITS-1:0]    timer_q [NUM_LEGS];
	logic                     walk_q;
	logic signed [GAIN_W-1:0] gx_q, gy_q, gz_q;
	logic signed [VEL_W-1:0]  body_q, vx_q, vy_q, vz_q;
	logic [V_W-1:0]           v_q;
	logic signed [H_W-1:0]    h_q;
	logic signed [P_W-1:0]    px_q, pz_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic [IDX_W-1:0]         out_leg_q;
	logic signed [VEL_W-1:0]  out_vx_q, out_vy_q, out_vz_q, out_body_q;
	logic                     out_last_q;

	// Timer of the current leg: cleared once it reaches the step duration.
	logic [TIMER_BITS-1:0] t_cur, t_eff, t_next;
	logic [TIMER_BITS:0]   t_sum;

	assign t_cur = timer_q[cmd.leg];
	assign t_eff = (CMP_W'(t_cur) >= CMP_W'(cfg.step_duration)) ? '0 : t_cur;
	assign swing = walk_q && (CMP_W'({t_eff, 2'b00}) < CMP_W'(cfg.step_duration));
	assign t_sum = {1'b0, t_eff} + (TIMER_BITS + 1)'(cfg.tick_increment);

	always_comb begin
		if (!walk_q) begin
			t_next = t_eff;
		end else if (t_sum[TIMER_BITS]) begin
			t_next = '1;
		end else begin
			t_next = t_sum[TIMER_BITS-1:0];
		end
	end

	// Operand selection for the shared multiplier, split into sign and magnitude.
	logic signed [MA_W-1:0] a_s;
	logic signed [MB_W-1:0] b_s;
	logic [MA_W-1:0]        a_mag;
	logic [MB_W-1:0]        b_mag;
	logic [PROD_W-1:0]      prod_d;

	always_comb begin
		case (cmd.op) inside
			OP_GX: begin
				a_s = MA_W'($signed({1'b0, cfg.scale}));
				b_s = MB_W'(cfg.forward_step);
			end
			OP_GY: begin
				a_s = MA_W'($signed({1'b0, cfg.scale}));
				b_s = MB_W'(cfg.side_step);
			end
			OP_GZ: begin
				a_s = MA_W'($signed({1'b0, cfg.scale}));
				b_s = MB_W'(cfg.step_height);
			end
			OP_PHASE: begin
				a_s = MA_W'($signed({1'b0, t_eff}));
				b_s = MB_W'($signed({1'b0, cfg.inv_duration}));
			end
			OP_X1, OP_X2, OP_X3, OP_Z1, OP_Z2, OP_Z3, OP_Z4: begin
				a_s = MA_W'(h_q);
				b_s = MB_W'($signed({1'b0, v_q}));
			end
			OP_VX: begin
				a_s = MA_W'(gx_q);
				b_s = MB_W'(px_q);
			end
			OP_VY: begin
				a_s = MA_W'(gy_q);
				b_s = MB_W'(px_q);
			end
			OP_VZ: begin
				a_s = MA_W'(gz_q);
				b_s = MB_W'(pz_q);
			end
			default: begin
				a_s = '0;
				b_s = '0;
			end
		endcase
		a_mag  = a_s[MA_W-1] ? MA_W'(-a_s) : MA_W'(a_s);
		b_mag  = b_s[MB_W-1] ? MB_W'(-b_s) : MB_W'(b_s);
		prod_d = a_mag * b_mag;
	end

	// Round half away from zero, restore the sign and add the Horner constant.
	logic [5:0]             sh;
	logic [PROD_W:0]        half, m_full;
	logic [PROD_W-1:0]      m;
	logic signed [R_W-1:0]  k, m_r, res;

	always_comb begin
		case (cmd.op) inside
			OP_GX, OP_GY, OP_GZ: sh = 6'd16;
			OP_PHASE:            sh = 6'd0;
			OP_VX, OP_VY, OP_VZ: sh = 6'd32;
			default:             sh = 6'd24;
		endcase
		case (cmd.op)
			OP_X1:   k = K_X1;
			OP_X3:   k = K_X3;
			OP_Z1:   k = K_Z1;
			OP_Z2:   k = K_Z2;
			default: k = '0;
		endcase
		half   = (sh == 6'd0) ? '0 : ((PROD_W + 1)'(1) << (sh - 6'd1));
		m_full = ({1'b0, prod_q} + half) >> sh;
		m      = m_full[PROD_W-1:0];
		m_r    = R_W'(m);
		res    = neg_q ? (k - m_r) : (k + m_r);
	end

	// Phase clamp and Horner start values.
	logic [V_W-1:0]        v_n;
	logic signed [H_W-1:0] v_ext, vq_ext, h_x0, h_z0;

	always_comb begin
		v_n    = (m > PHASE_LIM) ? V_ONE : {m[V_W-3:0], 2'b00};
		v_ext  = H_W'(v_n);
		vq_ext = H_W'(v_q);
		h_x0   = H_X0 + (v_ext <<< 7) + (v_ext <<< 4) + (v_ext <<< 2) + (v_ext <<< 1);
		h_z0   = H_Z0 - (vq_ext <<< 10) - (vq_ext <<< 9);
	end

	// Body velocity: forward gain divided by 2^8, rounded half away from zero, zero while not walking.
	logic [GAIN_W-1:0]       gmag;
	logic [GAIN_W:0]         gsum;
	logic [GAIN_W:0]         gdiv;
	logic signed [R_W-1:0]   body_r;
	logic signed [VEL_W-1:0] body_d;

	always_comb begin
		gmag   = gx_q[GAIN_W-1] ? GAIN_W'(-gx_q) : GAIN_W'(gx_q);
		gsum   = {1'b0, gmag} + (GAIN_W + 1)'(128);
		gdiv   = gsum >> 8;
		body_r = gx_q[GAIN_W-1] ? -R_W'(gdiv) : R_W'(gdiv);
		body_d = walk_q ? sat_vel(body_r) : '0;
	end

	// Control state: walk flag and leg timers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
			for (int i = 0; i < NUM_LEGS; i++) begin
				timer_q[i] <= timer_reset(i);
			end
		end else begin
			if (cmd.capture) begin
				walk_q <= in_walk;
			end
			if (cmd.load_out) begin
				timer_q[cmd.leg] <= t_next;
			end
		end
	end

	// Product register, write-back of each operation and the output word.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_d;
			neg_q  <= a_s[MA_W-1] ^ b_s[MB_W-1];
		end
		if (cmd.wb) begin
			case (cmd.op) inside
				OP_GX: gx_q <= GAIN_W'(res);
				OP_GY: begin
					gy_q   <= GAIN_W'(res);
					body_q <= body_d;
				end
				OP_GZ: gz_q <= GAIN_W'(res);
				OP_PHASE: begin
					v_q <= v_n;
					h_q <= h_x0;
				end
				OP_X1, OP_X2, OP_Z1, OP_Z2, OP_Z3: h_q <= H_W'(res);
				OP_X3: begin
					px_q <= P_W'(res);
					h_q  <= h_z0;
				end
				OP_Z4: pz_q <= P_W'(res);
				OP_VX: vx_q <= sat_vel(res);
				OP_VY: vy_q <= sat_vel(res);
				OP_VZ: vz_q <= sat_vel(res);
				default: ;
			endcase
		end
		if (cmd.leg_start) begin
			vx_q <= '0;
			vy_q <= '0;
			vz_q <= '0;
		end
		if (cmd.load_out) begin
			out_leg_q  <= IDX_W'(cmd.leg);
			out_vx_q   <= vx_q;
			out_vy_q   <= vy_q;
			out_vz_q   <= vz_q;
			out_body_q <= body_q;
			out_last_q <= (cmd.leg == LAST_LEG);
		end
	end

	assign out_leg  = out_leg_q;
	assign out_vx   = out_vx_q;
	assign out_vy   = out_vy_q;
	assign out_vz   = out_vz_q;
	assign out_body = out_body_q;
	assign out_last = out_last_q;

	`ASSERT_NEXT(a_stopped_zero, cmd.load_out && !walk_q, (out_vx_q == '0) && (out_vy_q == '0) && (out_vz_q == '0) && (out_body_q == '0))
	`ASSERT_IMP(a_phase_bound, cmd.mul && (cmd.op == OP_X1 || cmd.op == OP_X2 || cmd.op == OP_X3 || cmd.op == OP_Z1 || cmd.op == OP_Z2 || cmd.op == OP_Z3 || cmd.op == OP_Z4), v_q <= V_ONE)

endmodule

>>> src/walk_gait_swing_velocity_generator.sv
// A tick's first leg word follows the three gain products and the leg check, plus the phase,
// Horner and velocity products if that leg swings; a new tick waits for the previous tick's
// last word. Products share one 37 x 29 bit multiplier, each then rounded and written back.
// A tick with clock_running low gives no words and the block is ready again next cycle.
// Reset (arst_n low, asynchronous) idles the controller, drops the output word, loads the
// register reset values and sets the leg timers to 0, 750, 250 and 500 ms.
module walk_gait_swing_velocity_generator import wgsvg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // clock_running, walk_enabled, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // leg_index, foot_vel_x, foot_vel_y,
	                                         // foot_vel_z, body_vel_x, zero pad
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                    cfg;
	cmd_t                    cmd;
	logic                    swing;
	logic [IDX_W-1:0]        out_leg;
	logic signed [VEL_W-1:0] out_vx, out_vy, out_vz, out_body;

	assign cfg_ready = 1'b1;

	wgsvg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	wgsvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_run    (s_tdata[0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.swing     (swing),
		.cmd       (cmd)
	);

	wgsvg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_walk  (s_tdata[1]),
		.cmd      (cmd),
		.swing    (swing),
		.out_leg  (out_leg),
		.out_vx   (out_vx),
		.out_vy   (out_vy),
		.out_vz   (out_vz),
		.out_body (out_body),
		.out_last (m_tlast)
	);

	// Output word packing, first field in the lowest bits.
	assign m_tdata = {6'b0, out_body, out_vz, out_vy, out_vx, out_leg};

endmodule

>>> test/tb_walk_gait_swing_velocity_generator.sv
// Self-checking testbench for the gait swing velocity generator: random ticks, gaps and settings.
module tb_walk_gait_swing_velocity_generator;
	import wgsvg_pkg::*;

	// Index that names no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam longint Q24      = 64'sd1 << 24;
	localparam longint TIMER_MAX = (64'sd1 << TIMER_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;   // clock_running, walk_enabled, zero pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // leg_index, foot_vel_x, foot_vel_y, foot_vel_z, body_vel_x
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;

	// One expected leg word.
	typedef struct {
		logic [IDX_W-1:0] leg;
		logic [VEL_W-1:0] vel_x;
		logic [VEL_W-1:0] vel_y;
		logic [VEL_W-1:0] vel_z;
		logic [VEL_W-1:0] body_x;
		logic             last;
	} leg_word_t;

	// Gait predictor with its own register copy and leg timers, plus the expected words.
	class gait_scoreboard;
		logic signed [STEP_W-1:0] fwd_step;
		logic signed [STEP_W-1:0] side_step;
		logic signed [STEP_W-1:0] lift_height;
		logic [DUR_W-1:0]         duration;
		logic [INC_W-1:0]         increment;
		logic [INV_W-1:0]         inv_dur;
		logic [TIMER_BITS-1:0]    timer [NUM_LEGS];
		leg_word_t                expected_q [$];
		int                       errors;
		bit                       timer_clamped;

		function new();
			fwd_step = STEP_W'(19661);
			side_step = '0;
			lift_height = STEP_W'(6554);
			duration = DUR_W'(1000);
			increment = INC_W'(1);
			inv_dur = INV_W'(16777);
			errors = 0;
			timer_clamped = 1'b0;
			// Legs start staggered by a quarter of the default cycle.
			for (int k = 0; k < NUM_LEGS; k++) begin
				case (k % 4)
					0: timer[k] = '0;
					1: timer[k] = TIMER_BITS'(750);
					2: timer[k] = TIMER_BITS'(250);
					default: timer[k] = TIMER_BITS'(500);
				endcase
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FORWARD_STEP:   fwd_step = data[STEP_W-1:0];
				REG_SIDE_STEP:      side_step = data[STEP_W-1:0];
				REG_STEP_HEIGHT:    lift_height = data[STEP_W-1:0];
				REG_STEP_DURATION:  duration = data[DUR_W-1:0];
				REG_TICK_INCREMENT: increment = data[INC_W-1:0];
				REG_INV_DURATION:   inv_dur = data[INV_W-1:0];
				default: ;
			endcase
		endfunction

		// round(a * b / 2^sh), half away from zero.
		function longint rnd_mul(longint a, longint b, int sh);
			logic [127:0] ma;
			logic [127:0] mb;
			logic [127:0] m;
			bit neg;
			neg = (a < 0) != (b < 0);
			ma = 128'((a < 0) ? -a : a);
			mb = 128'((b < 0) ? -b : b);
			m = ma * mb;
			m = (m + (128'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
		endfunction

		function logic [VEL_W-1:0] sat24(longint v);
			if (v > 8388607)
				return 24'h7FFFFF;
			if (v < -8388608)
				return 24'h800000;
			return v[VEL_W-1:0];
		endfunction

		// A tick that was accepted: with run set, queue the four leg words and, while walking, advance the timers.
		function void note_tick(bit run, bit walk);
			longint scale, gx, gy, gz, body;
			longint t, vp, v, h, px, pz, vx, vy, vz, nt;
			leg_word_t w;
			if (!run)
				return;
			scale = longint'(inv_dur) * 1000;
			gx = rnd_mul(scale, longint'(fwd_step), 16);
			gy = rnd_mul(scale, longint'(side_step), 16);
			gz = rnd_mul(scale, longint'(lift_height), 16);
			body = walk ? rnd_mul(gx, 1, 8) : 0;
			for (int k = 0; k < NUM_LEGS; k++) begin
				vx = 0;
				vy = 0;
				vz = 0;
				if (timer[k] >= duration)
					timer[k] = '0;
				t = longint'(timer[k]);
				// Swing covers the first quarter of the step.
				if (walk && t * 4 < longint'(duration)) begin
					vp = (t * longint'(inv_dur)) << 2;
					v = (vp > Q24) ? Q24 : vp;
					h = 150 * v - 300 * Q24;
					h = rnd_mul(h, v, 24) + 150 * Q24;
					h = rnd_mul(h, v, 24);
					px = rnd_mul(h, v, 24) - Q24;
					h = 3840 * Q24 - 1536 * v;
					h = rnd_mul(h, v, 24) - 3072 * Q24;
					h = rnd_mul(h, v, 24) + 768 * Q24;
					h = rnd_mul(h, v, 24);
					pz = rnd_mul(h, v, 24);
					vx = rnd_mul(gx, px, 32);
					vy = rnd_mul(gy, px, 32);
					vz = rnd_mul(gz, pz, 32);
				end
				if (walk) begin
					nt = t + longint'(increment);
					if (nt > TIMER_MAX) begin
						nt = TIMER_MAX;
						timer_clamped = 1'b1;
					end
					timer[k] = nt[TIMER_BITS-1:0];
				end
				w.leg = k[IDX_W-1:0];
				w.vel_x = sat24(vx);
				w.vel_y = sat24(vy);
				w.vel_z = sat24(vz);
				w.body_x = sat24(body);
				w.last = (k == NUM_LEGS - 1);
				expected_q.push_back(w);
			end
		endfunction

		function void cmp(string field, logic signed [63:0] exp_v, logic signed [63:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, actual %0d", field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_word(logic [OUT_W-1:0] d, logic last);
			leg_word_t w;
			if (expected_q.size() == 0) begin
				$error("unexpected word for leg %0d", d[IDX_W-1:0]);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			cmp("leg_index", w.leg, d[IDX_W-1:0]);
			cmp("foot_vel_x", $signed(w.vel_x), $signed(d[IDX_W +: VEL_W]));
			cmp("foot_vel_y", $signed(w.vel_y), $signed(d[IDX_W + VEL_W +: VEL_W]));
			cmp("foot_vel_z", $signed(w.vel_z), $signed(d[IDX_W + 2*VEL_W +: VEL_W]));
			cmp("body_vel_x", $signed(w.body_x), $signed(d[IDX_W + 3*VEL_W +: VEL_W]));
			cmp("last_leg", w.last, last);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	gait_scoreboard sb;

	walk_gait_swing_velocity_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random ready bursts, or one long hold-off on request.
	always begin
		@(posedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end else begin
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(posedge clk);
		end
	end

	// Every accepted leg word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	// Keep the field bits, put random junk in the unused upper bits of the word.
	function automatic logic [CFG_DATA_W-1:0] with_junk(int val, int w);
		logic [CFG_DATA_W-1:0] mask;
		mask = (CFG_DATA_W'(1) << w) - 1'b1;
		return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
	endfunction

	function automatic int pick_step();
		if ($urandom_range(0, 1) == 0)
			return int'($urandom_range(0, (1 << STEP_W) - 1)) - (1 << (STEP_W - 1));
		return int'($urandom_range(0, 40000)) - 20000;
	endfunction

	// Wait until every expected word has arrived and the block has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes need no second assignment.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic program_gait(int fwd, int side, int lift, int dur, int inc, int inv,
			bit poke_unused);
		settle();
		cfg_write(REG_FORWARD_STEP, with_junk(fwd, STEP_W));
		cfg_write(REG_SIDE_STEP, with_junk(side, STEP_W));
		cfg_write(REG_STEP_HEIGHT, with_junk(lift, STEP_W));
		cfg_write(REG_STEP_DURATION, with_junk(dur, DUR_W));
		cfg_write(REG_TICK_INCREMENT, with_junk(inc, INC_W));
		cfg_write(REG_INV_DURATION, with_junk(inv, INV_W));
		if (poke_unused)
			cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Duration spans 4 to under 25 increments so a short phase covers whole gait cycles.
	task automatic random_gait(bit poke_unused);
		int inc, dur, inv;
		inc = $urandom_range(1, 255);
		dur = inc * $urandom_range(4, 24) + $urandom_range(0, inc - 1);
		inv = ((1 << 24) + dur / 2) / dur;
		if ($urandom_range(0, 5) == 0)
			inv = $urandom_range(0, (1 << INV_W) - 1);
		program_gait(pick_step(), pick_step(), pick_step(), dur, inc, inv, poke_unused);
	endtask

	// Leaves s_tvalid high after acceptance; the next tick or a gap decides its value.
	task automatic send_tick(bit run, bit walk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - 2){1'b0}}, walk, run};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_tick(run, walk);
	endtask

	task automatic random_tick(int run_pct, int walk_pct);
		send_tick($urandom_range(0, 99) < run_pct, $urandom_range(0, 99) < walk_pct);
	endtask

	initial begin : main_seq
		int n;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every combination of the two tick flags.
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		repeat (3) send_tick(1'b1, 1'b1);

		// Extreme gains with the shortest legal step; outputs saturate.
		program_gait(131071, -131072, -1, 4, 1, 4194304, 1'b0);
		repeat (5) send_tick(1'b1, 1'b1);

		// Zero duration: no leg ever swings; unknown index written too.
		program_gait(-131072, 131071, 131071, 0, 255, (1 << INV_W) - 1, 1'b1);
		repeat (3) send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);

		// Reciprocal ten times too large, so the phase clamps at its quarter-step value early in the swing.
		program_gait(19661, 3000, 6554, 2000, 100, 83886, 1'b0);
		repeat (6) send_tick(1'b1, 1'b1);

		// Random settings; the second phase starts with a long output hold-off.
		for (int p = 0; p < 5; p++) begin
			random_gait(p == 0);
			if (p == 1)
				hold_req = 1'b1;
			repeat (25) random_tick(90, 80);
		end

		// Longest step with a coarse increment, run until a timer saturates.
		program_gait(pick_step(), pick_step(), pick_step(), 65535, 251, 256, 1'b0);
		n = 0;
		while (!sb.timer_clamped && n < 600) begin
			random_tick(97, 95);
			n++;
		end
		repeat (10) random_tick(97, 95);

		// Closing phase at full rate on both sides.
		gaps_on = 1'b0;
		random_gait(1'b0);
		repeat (45) random_tick(90, 80);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
